// File: rtl/swgc_pkg.sv
// Shared types and constants for the sliding-window G/C fraction block.
`default_nettype none

package swgc_pkg;

    // Window and result geometry
    localparam int MAX_WINDOW = 1024;
    localparam int PTR_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 11;
    localparam int FRAC_BITS  = 16;
    localparam int FRAC_W     = FRAC_BITS + 1;
    localparam int CHAR_W     = 8;
    localparam int DIV_STEPS  = FRAC_BITS + 1;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Bases that count as G/C
    localparam logic [CHAR_W-1:0] CH_G_UP = 8'h47;
    localparam logic [CHAR_W-1:0] CH_C_UP = 8'h43;
    localparam logic [CHAR_W-1:0] CH_G_LO = 8'h67;
    localparam logic [CHAR_W-1:0] CH_C_LO = 8'h63;

    // Result status codes
    localparam logic STATUS_WINDOW = 1'b0;
    localparam logic STATUS_SHORT  = 1'b1;

    // One classified base
    typedef struct packed {
        logic mark;
        logic last;
    } t_item;

    // Head of the front queue as seen by the back end
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_head;

    // Back-end sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_DIV,
        ST_OUT
    } t_back_state;

endpackage

`default_nettype wire

// File: rtl/sliding_window_gc_fraction_core.sv
// Top level of the sliding-window G/C fraction block.
//
// Input channel: i_valid/o_ready carry one ASCII base (i_base_char) and a flag
// (i_seq_last) marking the last base of a sequence. Output channel: o_valid/
// i_ready carry the G/C base count, gc_fraction (unsigned Q1.16, truncated),
// status and result_last. Once a window is full every base yields one result; a
// sequence ending before its window fills yields one result with status set.
// i_cfg_we writes the window length (0 taken as 1, above 1024 as 1024) and
// clears the sequence state; write it only while the block is idle.
// The back end handles one base at a time: it pops it, updates the count
// and, for a window result, runs the 17-step serial divider before output.
// A two-entry queue in front accepts bases while the back end works.
// A short-sequence result skips the divider and goes straight to the result
// register, which drives o_valid and the result outputs.
// Reset (synchronous, active low) empties the queue, drops any pending result,
// clears the sequence state and sets the window length to 1.
// When the receiver stalls, the result holds in the output register and the
// back end waits; the front queue keeps taking bases until it is full.
`default_nettype none

module sliding_window_gc_fraction_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [swgc_pkg::CHAR_W-1:0]  i_base_char,
    input  wire logic                         i_seq_last,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [swgc_pkg::LEN_W-1:0]        o_gc_bases,
    output logic [swgc_pkg::FRAC_W-1:0]       o_gc_fraction,
    output logic                              o_status,
    output logic                              o_result_last,
    input  wire logic                         i_cfg_we,
    input  wire logic [swgc_pkg::LEN_W-1:0]   i_cfg_wdata
);

    swgc_pkg::t_head head;
    logic            pop;

    // Accept and classify
    swgc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_base_char (i_base_char),
        .i_seq_last  (i_seq_last),
        .o_head      (head),
        .i_pop       (pop)
    );

    // Window count and fraction
    swgc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_gc_bases    (o_gc_bases),
        .o_gc_fraction (o_gc_fraction),
        .o_status      (o_status),
        .o_result_last (o_result_last)
    );

endmodule

`default_nettype wire

// File: rtl/swgc_front.sv
// Front end: accepts bases, classifies G/C, and buffers them in a two-entry queue.
`default_nettype none

module swgc_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [swgc_pkg::CHAR_W-1:0] i_base_char,
    input  wire logic                        i_seq_last,
    output swgc_pkg::t_head                  o_head,
    input  wire logic                        i_pop
);

    swgc_pkg::t_item r_q [2];
    logic            r_wr_ptr, n_wr_ptr;
    logic            r_rd_ptr, n_rd_ptr;
    logic [1:0]      r_cnt, n_cnt;
    logic            push;
    logic            pop;
    swgc_pkg::t_item in_item;

    // Classify the incoming base, case ignored
    always_comb begin
        in_item.mark = (i_base_char == swgc_pkg::CH_G_UP) || (i_base_char == swgc_pkg::CH_C_UP)
                    || (i_base_char == swgc_pkg::CH_G_LO) || (i_base_char == swgc_pkg::CH_C_LO);
        in_item.last = i_seq_last;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_cnt != 2'd0);

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rd_ptr];

    // Queue pointers and fill count
    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop  ? ~r_rd_ptr : r_rd_ptr;
        n_cnt    = r_cnt + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/swgc_back.sv
// Back end: mark ring, running count, serial divider and result register.
`default_nettype none

module swgc_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire swgc_pkg::t_head              i_head,
    output logic                              o_pop,
    input  wire logic                         i_cfg_we,
    input  wire logic [swgc_pkg::LEN_W-1:0]   i_cfg_wdata,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [swgc_pkg::LEN_W-1:0]        o_gc_bases,
    output logic [swgc_pkg::FRAC_W-1:0]       o_gc_fraction,
    output logic                              o_status,
    output logic                              o_result_last
);

    localparam int LW = swgc_pkg::LEN_W;
    localparam int PW = swgc_pkg::PTR_W;
    localparam int FW = swgc_pkg::FRAC_W;
    localparam int SW = swgc_pkg::STEP_W;

    swgc_pkg::t_back_state r_state, n_state;

    logic          r_ring [swgc_pkg::MAX_WINDOW];
    logic          r_rd;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [LW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_count, n_count;
    logic [LW-1:0] r_win, n_win;
    logic          r_mark, r_last;
    logic          r_err, n_err;
    logic [LW-1:0] r_res_count, n_res_count;
    logic [LW:0]   r_rem, n_rem;
    logic [FW-1:0] r_quo, n_quo;
    logic [SW-1:0] r_step, n_step;
    logic          r_out_valid, n_out_valid;
    logic          out_load;

    logic [PW-1:0] old_addr;
    logic          full_before;
    logic          drop;
    logic [LW-1:0] upd_fill;
    logic [LW-1:0] upd_count;
    logic          full_after;
    logic [LW:0]   trial;
    logic          qbit;
    logic [LW-1:0] eff_win;

    // Clamp the written window length to 1..MAX_WINDOW
    always_comb begin
        if (i_cfg_wdata == '0) begin
            eff_win = LW'(1);
        end else if (i_cfg_wdata > LW'(swgc_pkg::MAX_WINDOW)) begin
            eff_win = LW'(swgc_pkg::MAX_WINDOW);
        end else begin
            eff_win = i_cfg_wdata;
        end
    end

    // Slot of the base leaving the window (ring size is a power of two)
    assign old_addr = r_ptr - r_win[PW-1:0];

    // Running count update, using the mark read from the ring
    always_comb begin
        full_before = (r_fill >= r_win);
        drop        = full_before && r_rd && (r_count != '0);
        upd_fill    = full_before ? r_fill : r_fill + LW'(1);
        upd_count   = r_count - {{(LW-1){1'b0}}, drop} + {{(LW-1){1'b0}}, r_mark};
        full_after  = (upd_fill >= r_win);
    end

    // One restoring-division step; the first step has no shift
    always_comb begin
        trial = (r_step == '0) ? r_rem : {r_rem[LW-1:0], 1'b0};
        qbit  = (trial >= {1'b0, r_win});
    end

    assign out_load = (r_state == swgc_pkg::ST_OUT) && (!r_out_valid || i_ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            swgc_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    n_state = swgc_pkg::ST_UPD;
                end
            end
            swgc_pkg::ST_UPD: begin
                if (full_after) begin
                    n_state = swgc_pkg::ST_DIV;
                end else if (r_last) begin
                    n_state = swgc_pkg::ST_OUT;
                end else begin
                    n_state = swgc_pkg::ST_IDLE;
                end
            end
            swgc_pkg::ST_DIV: begin
                if (r_step == SW'(swgc_pkg::DIV_STEPS - 1)) begin
                    n_state = swgc_pkg::ST_OUT;
                end
            end
            swgc_pkg::ST_OUT: begin
                if (out_load) begin
                    n_state = swgc_pkg::ST_IDLE;
                end
            end
            default: n_state = swgc_pkg::ST_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = swgc_pkg::ST_IDLE;
        end
    end

    // Outputs and datapath next values
    always_comb begin
        o_pop       = 1'b0;
        n_ptr       = r_ptr;
        n_fill      = r_fill;
        n_count     = r_count;
        n_win       = r_win;
        n_err       = r_err;
        n_res_count = r_res_count;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            swgc_pkg::ST_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    n_ptr = r_ptr + PW'(1);
                end
            end
            swgc_pkg::ST_UPD: begin
                n_fill      = upd_fill;
                n_count     = upd_count;
                n_res_count = upd_count;
                n_rem       = {1'b0, upd_count};
                n_quo       = '0;
                n_step      = '0;
                n_err       = !full_after;
                if (r_last) begin
                    n_ptr   = '0;
                    n_fill  = '0;
                    n_count = '0;
                end
            end
            swgc_pkg::ST_DIV: begin
                n_rem  = qbit ? trial - {1'b0, r_win} : trial;
                n_quo  = {r_quo[FW-2:0], qbit};
                n_step = r_step + SW'(1);
            end
            swgc_pkg::ST_OUT: begin
                if (out_load) begin
                    n_out_valid = 1'b1;
                end
            end
            default: ;
        endcase
        // A window write abandons the sequence in progress
        if (i_cfg_we) begin
            o_pop   = 1'b0;
            n_win   = eff_win;
            n_ptr   = '0;
            n_fill  = '0;
            n_count = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swgc_pkg::ST_IDLE;
            r_ptr       <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_win       <= LW'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_win       <= n_win;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_err       <= n_err;
        r_res_count <= n_res_count;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_step      <= n_step;
        if (o_pop) begin
            r_mark <= i_head.item.mark;
            r_last <= i_head.item.last;
        end
    end

    // Mark ring: read the leaving base and write the new one on a pop
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd          <= r_ring[old_addr];
            r_ring[r_ptr] <= i_head.item.mark;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_gc_bases    <= r_err ? '0 : r_res_count;
            o_gc_fraction <= r_err ? '0 : r_quo;
            o_status      <= r_err ? swgc_pkg::STATUS_SHORT : swgc_pkg::STATUS_WINDOW;
            o_result_last <= r_err ? 1'b1 : r_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/swgc_checker.sv
// Port-level checks for the sliding-window G/C fraction block, bound to the top level.
`default_nettype none

module swgc_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [swgc_pkg::LEN_W-1:0]  i_gc_bases,
    input wire logic [swgc_pkg::FRAC_W-1:0] i_gc_fraction,
    input wire logic                        i_status,
    input wire logic                        i_result_last
);

    // A stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_gc_bases)
            && $stable(i_gc_fraction) && $stable(i_status) && $stable(i_result_last))
        else $error("result changed while stalled");

    // A short-sequence result closes the sequence and carries zeros
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == swgc_pkg::STATUS_SHORT) |->
            i_result_last && (i_gc_bases == '0) && (i_gc_fraction == '0))
        else $error("short-sequence result malformed");

    // Fraction never exceeds one
    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_gc_fraction <= swgc_pkg::FRAC_W'(1 << swgc_pkg::FRAC_BITS))
        else $error("fraction above one");

    // Count bounded by the largest window
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_gc_bases <= swgc_pkg::LEN_W'(swgc_pkg::MAX_WINDOW))
        else $error("count above largest window");

    // Reset drops any pending result
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind sliding_window_gc_fraction_core swgc_checker u_swgc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_valid),
    .i_out_ready   (i_ready),
    .i_gc_bases    (o_gc_bases),
    .i_gc_fraction (o_gc_fraction),
    .i_status      (o_status),
    .i_result_last (o_result_last)
);

`default_nettype wire
